// ===== rtl/hed_pkg.sv =====
// hed_pkg: constants, state and command types shared by the entity decoder
// controller, datapath and top level
// no dependencies
`default_nettype none

package hed_pkg;

	// longest entity span: the ampersand and the body, without the semicolon
	localparam int MAX_ENTITY_SPAN = 10;
	localparam int BODY_MAX        = MAX_ENTITY_SPAN - 1;
	// held count reaches MAX_ENTITY_SPAN for one rescan (body plus new byte)
	localparam int CNT_W           = $clog2(MAX_ENTITY_SPAN + 1);
	localparam int IDX_W           = $clog2(MAX_ENTITY_SPAN);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESCAN,
		ST_FL_AMP,
		ST_FL_BODY,
		ST_DEC,
		ST_NUM,
		ST_LIT_AMP,
		ST_LIT_BODY
	} hed_state_t;

	// source of an emitted byte
	typedef enum logic [2:0] {
		EM_BYTE,
		EM_AMP,
		EM_SEMI,
		EM_HEAD,
		EM_IDX,
		EM_NAMED,
		EM_CODE
	} hed_emit_t;

	typedef struct packed {
		logic      in_ready;
		logic      emit;
		hed_emit_t emit_sel;
		logic      finish;
		logic      hold;
		logic      set_ent;
		logic      ent_off;
		logic      drop;
		logic      shift;
		logic      idx_clr;
		logic      idx_inc;
		logic      num_init;
		logic      num_step;
	} hed_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic emit_ok;
		logic stg_valid;
		logic out_free;
		logic last;
		logic in_ent;
		logic b_is_amp;
		logic b_is_semi;
		logic cnt_full;
		logic cnt_zero;
		logic head_is_amp;
		logic idx_end;
		logic named_hit;
		logic num_start;
		logic digit_bad;
		logic code_ok;
	} hed_status_t;

endpackage

`default_nettype wire

// ===== rtl/hed_in_if.sv =====
// hed_in_if: input text channel, one byte per transfer
// no dependencies
`default_nettype none

interface hed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       text_last;

	modport source(output valid, in_byte, text_last, input ready);
	modport sink(input valid, in_byte, text_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/hed_out_if.sv =====
// hed_out_if: decoded text channel, one byte per transfer
// no dependencies
`default_nettype none

interface hed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       text_done;

	modport source(output valid, out_byte, run_last, text_done, input ready);
	modport sink(input valid, out_byte, run_last, text_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/hed_dp.sv =====
// hed_dp: entity decoder datapath: held body bytes, numeric accumulator,
// staging byte and output register
// depends on hed_pkg, hed_in_if, hed_out_if
`default_nettype none

module hed_dp
	import hed_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	hed_in_if.sink          raw,
	hed_out_if.source       decoded,
	input  wire hed_cmd_t   cmd,
	output hed_status_t     sts
);

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CODE_CAP = 8'd128;

	logic [7:0]       held_q [MAX_ENTITY_SPAN];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic             in_ent_q;
	logic [7:0]       b_q;
	logic             last_q;
	logic             hex_q;
	logic [7:0]       code_q;
	logic             stg_valid_q;
	logic [7:0]       stg_byte_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             run_last_q;
	logic             text_done_q;

	logic [7:0]  cur;
	logic [3:0]  dig;
	logic        dig_ok;
	logic        dig_dec;
	logic [11:0] prod;
	logic [11:0] sum;
	logic [7:0]  code_next;
	logic        named_hit;
	logic [7:0]  named_byte;
	logic        hex_start;
	logic [7:0]  emit_byte;
	logic        out_free;
	logic        push;

	assign cur = held_q[idx_q[IDX_W-1:0]];

	// hex digit value of the byte at the walk index
	always_comb begin
		dig     = '0;
		dig_ok  = 1'b0;
		dig_dec = 1'b0;
		if (cur inside {[8'h30:8'h39]}) begin
			dig     = 4'(cur - 8'h30);
			dig_ok  = 1'b1;
			dig_dec = 1'b1;
		end else if (cur inside {[8'h61:8'h66]}) begin
			dig    = 4'(cur - 8'h57);
			dig_ok = 1'b1;
		end else if (cur inside {[8'h41:8'h46]}) begin
			dig    = 4'(cur - 8'h37);
			dig_ok = 1'b1;
		end
	end

	// saturating accumulate, code stays at or below the cap
	always_comb begin
		prod = hex_q ? {code_q, 4'b0000} : ({4'b0000, code_q} << 3) + ({4'b0000, code_q} << 1);
		sum  = prod + {8'h00, dig};
		code_next = (sum > {4'b0000, CODE_CAP}) ? CODE_CAP : sum[7:0];
	end

	always_comb begin
		named_hit  = 1'b1;
		named_byte = '0;
		if (cnt_q == CNT_W'(3) && {held_q[0], held_q[1], held_q[2]} == "amp") begin
			named_byte = CH_AMP;
		end else if (cnt_q == CNT_W'(2) && {held_q[0], held_q[1]} == "lt") begin
			named_byte = 8'h3C;
		end else if (cnt_q == CNT_W'(2) && {held_q[0], held_q[1]} == "gt") begin
			named_byte = 8'h3E;
		end else if (cnt_q == CNT_W'(4)
			&& {held_q[0], held_q[1], held_q[2], held_q[3]} == "quot") begin
			named_byte = 8'h22;
		end else if (cnt_q == CNT_W'(4)
			&& {held_q[0], held_q[1], held_q[2], held_q[3]} == "apos") begin
			named_byte = 8'h27;
		end else if (cnt_q == CNT_W'(4)
			&& {held_q[0], held_q[1], held_q[2], held_q[3]} == "nbsp") begin
			named_byte = CH_SPACE;
		end else begin
			named_hit = 1'b0;
		end
	end

	assign hex_start = (cnt_q > CNT_W'(2)) && (held_q[1] == "x" || held_q[1] == "X");

	always_comb begin
		case (cmd.emit_sel)
			EM_BYTE:  emit_byte = b_q;
			EM_AMP:   emit_byte = CH_AMP;
			EM_SEMI:  emit_byte = CH_SEMI;
			EM_HEAD:  emit_byte = held_q[0];
			EM_IDX:   emit_byte = cur;
			EM_NAMED: emit_byte = named_byte;
			EM_CODE:  emit_byte = code_q;
			default:  emit_byte = b_q;
		endcase
	end

	assign out_free = !out_valid_q || decoded.ready;
	assign push     = stg_valid_q && (cmd.emit || cmd.finish);

	// input capture
	always_ff @(posedge clk) begin
		if (raw.valid && cmd.in_ready) begin
			b_q    <= raw.in_byte;
			last_q <= raw.text_last;
		end
	end

	// held body: written at the fill count, shifted toward slot zero on rescan
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ENTITY_SPAN; i++) begin
			if (cmd.shift) begin
				if (i < MAX_ENTITY_SPAN - 1) begin
					held_q[i] <= held_q[i + 1];
				end
			end else if (cmd.hold && cnt_q == CNT_W'(i)) begin
				held_q[i] <= b_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			in_ent_q <= 1'b0;
		end else begin
			if (cmd.drop) begin
				cnt_q    <= '0;
				in_ent_q <= 1'b0;
			end else begin
				if (cmd.hold) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else if (cmd.shift) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
				if (cmd.set_ent) begin
					in_ent_q <= 1'b1;
				end else if (cmd.ent_off) begin
					in_ent_q <= 1'b0;
				end
			end
		end
	end

	// walk index and numeric accumulator
	always_ff @(posedge clk) begin
		if (cmd.num_init) begin
			hex_q  <= hex_start;
			idx_q  <= hex_start ? CNT_W'(2) : CNT_W'(1);
			code_q <= '0;
		end else if (cmd.num_step) begin
			idx_q  <= idx_q + CNT_W'(1);
			code_q <= code_next;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	// staging byte: held back until it is known whether it closes the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			stg_valid_q <= 1'b1;
		end else if (cmd.finish) begin
			stg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			stg_byte_q <= emit_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (decoded.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_byte_q  <= stg_byte_q;
			run_last_q  <= cmd.finish;
			text_done_q <= cmd.finish && last_q;
		end
	end

	assign raw.ready         = cmd.in_ready;
	assign decoded.valid     = out_valid_q;
	assign decoded.out_byte  = out_byte_q;
	assign decoded.run_last  = run_last_q;
	assign decoded.text_done = text_done_q;

	always_comb begin
		sts.in_valid    = raw.valid;
		sts.emit_ok     = !stg_valid_q || out_free;
		sts.stg_valid   = stg_valid_q;
		sts.out_free    = out_free;
		sts.last        = last_q;
		sts.in_ent      = in_ent_q;
		sts.b_is_amp    = b_q == CH_AMP;
		sts.b_is_semi   = b_q == CH_SEMI;
		sts.cnt_full    = cnt_q == CNT_W'(BODY_MAX);
		sts.cnt_zero    = cnt_q == '0;
		sts.head_is_amp = held_q[0] == CH_AMP;
		sts.idx_end     = idx_q == cnt_q;
		sts.named_hit   = named_hit;
		sts.num_start   = (cnt_q != '0) && (held_q[0] == CH_HASH);
		sts.digit_bad   = !dig_ok || (!hex_q && !dig_dec);
		sts.code_ok     = (code_q != '0) && (code_q < CODE_CAP);
	end

endmodule

`default_nettype wire

// ===== rtl/hed_ctrl.sv =====
// hed_ctrl: entity decoder sequencer, drives datapath commands from status
// depends on hed_pkg
`default_nettype none

module hed_ctrl
	import hed_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire hed_status_t sts,
	output hed_cmd_t         cmd
);

	hed_state_t state_q;
	hed_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sts.in_valid && sts.emit_ok) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!sts.in_ent) begin
					state_d = (sts.b_is_amp && sts.last) ? ST_FL_AMP : ST_IDLE;
				end else if (sts.b_is_semi) begin
					state_d = ST_DEC;
				end else if (!sts.cnt_full) begin
					state_d = sts.last ? ST_FL_AMP : ST_IDLE;
				end else begin
					state_d = ST_RESCAN;
				end
			end
			ST_RESCAN: begin
				if (sts.in_ent || sts.cnt_zero) begin
					state_d = (sts.in_ent && sts.last) ? ST_FL_AMP : ST_IDLE;
				end
			end
			ST_FL_AMP: begin
				if (sts.emit_ok) begin
					state_d = ST_FL_BODY;
				end
			end
			ST_FL_BODY: begin
				if (sts.idx_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_DEC: begin
				if (sts.named_hit) begin
					if (sts.emit_ok) begin
						state_d = ST_IDLE;
					end
				end else if (sts.num_start) begin
					state_d = ST_NUM;
				end else begin
					state_d = ST_LIT_AMP;
				end
			end
			ST_NUM: begin
				if (sts.idx_end) begin
					if (!sts.code_ok) begin
						state_d = ST_LIT_AMP;
					end else if (sts.emit_ok) begin
						state_d = ST_IDLE;
					end
				end else if (sts.digit_bad) begin
					state_d = ST_LIT_AMP;
				end
			end
			ST_LIT_AMP: begin
				if (sts.emit_ok) begin
					state_d = ST_LIT_BODY;
				end
			end
			ST_LIT_BODY: begin
				if (sts.idx_end && sts.emit_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.emit_sel = EM_BYTE;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = sts.emit_ok;
				cmd.finish   = sts.stg_valid && sts.out_free;
			end
			ST_EXEC: begin
				if (!sts.in_ent) begin
					if (sts.b_is_amp) begin
						cmd.set_ent = 1'b1;
					end else begin
						cmd.emit = 1'b1;
					end
				end else if (sts.b_is_semi) begin
					cmd.emit = 1'b0;
				end else if (!sts.cnt_full) begin
					cmd.hold = 1'b1;
				end else begin
					// no semicolon in reach: ampersand goes out, body is rescanned
					cmd.hold     = 1'b1;
					cmd.ent_off  = 1'b1;
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_AMP;
				end
			end
			ST_RESCAN: begin
				if (!sts.in_ent && !sts.cnt_zero) begin
					if (sts.head_is_amp) begin
						cmd.shift   = 1'b1;
						cmd.set_ent = 1'b1;
					end else if (sts.emit_ok) begin
						cmd.shift    = 1'b1;
						cmd.emit     = 1'b1;
						cmd.emit_sel = EM_HEAD;
					end
				end
			end
			ST_FL_AMP, ST_LIT_AMP: begin
				if (sts.emit_ok) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_AMP;
					cmd.idx_clr  = 1'b1;
				end
			end
			ST_FL_BODY: begin
				if (sts.idx_end) begin
					cmd.drop = 1'b1;
				end else if (sts.emit_ok) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EM_IDX;
					cmd.idx_inc  = 1'b1;
				end
			end
			ST_DEC: begin
				if (sts.named_hit) begin
					if (sts.emit_ok) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = EM_NAMED;
						cmd.drop     = 1'b1;
					end
				end else if (sts.num_start) begin
					cmd.num_init = 1'b1;
				end
			end
			ST_NUM: begin
				if (sts.idx_end) begin
					if (sts.code_ok && sts.emit_ok) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = EM_CODE;
						cmd.drop     = 1'b1;
					end
				end else if (!sts.digit_bad) begin
					cmd.num_step = 1'b1;
				end
			end
			ST_LIT_BODY: begin
				if (sts.emit_ok) begin
					cmd.emit = 1'b1;
					if (sts.idx_end) begin
						cmd.emit_sel = EM_SEMI;
						cmd.drop     = 1'b1;
					end else begin
						cmd.emit_sel = EM_IDX;
						cmd.idx_inc  = 1'b1;
					end
				end
			end
			default: cmd.emit_sel = EM_BYTE;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/html_entity_decoder.sv =====
// html_entity_decoder: top level of the entity decoder, joins the sequencer
// and the datapath; depends on hed_pkg, hed_in_if, hed_out_if, hed_ctrl, hed_dp
//
// usage
// - raw: input text, one byte per transfer (valid/ready); text_last marks
//   the final byte of a text and flushes any pending entity literally
// - decoded: output text, one byte per transfer; run_last flags the final
//   byte caused by one input transfer, text_done the final byte of the text
// - a plain byte is captured, then staged; the staged byte moves into the
//   output register in the following idle cycle once the output is free
// - an input byte that only extends a pending entity is captured, then held
// - a semicolon moves the sequencer to a decode state that picks the path; a
//   named entity goes out from that state; a numeric code walks its digits,
//   then sends the code; a literal replay sends the ampersand, then each body
//   byte and the semicolon, after the numeric walk when there is one
// - a failed span (no semicolon within reach) replays one held byte per cycle unless the output stalls
// - each output byte passes through a one-entry staging register so that the
//   last byte of an item is known before it is released
// - reset clears the sequencer, the entity flag, the held count and all
//   valid flags; held bytes themselves are not cleared
// - when decoded stalls, the output register holds its byte and the
//   sequencer waits at the next emit; raw is not taken while a staged byte
//   has nowhere to go
`default_nettype none

module html_entity_decoder
	import hed_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	hed_in_if.sink    raw,
	hed_out_if.source decoded
);

	// command and status between sequencer and datapath
	hed_cmd_t    cmd;
	hed_status_t sts;

	hed_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// body store, numeric accumulator, staging and output registers
	hed_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.raw     (raw),
		.decoded (decoded),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule

`default_nettype wire

// ===== test/html_entity_decoder_test.sv =====
// html_entity_decoder_test: self-checking bench for the entity decoder, with its own
// predictor of the decoded text, a scoreboard class and random idling on both channels
// depends on hed_pkg, hed_in_if, hed_out_if and html_entity_decoder
`timescale 1ns / 100ps

module html_entity_decoder_test
	import hed_pkg::*;
();

	// characters the decoder treats specially
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_UA    = 8'h41;
	// numeric codes saturate here and are then left literal
	localparam int unsigned CODE_CAP = 128;
	// an item gives at most the ampersand plus a full rescanned span
	localparam int unsigned MAX_BYTES_PER_ITEM = MAX_ENTITY_SPAN + 1;
	// watchdog bound on the length of a run, in clock cycles
	localparam int unsigned CYCLE_LIMIT = 400000;
	// cycles to watch for stray output once the text is done
	localparam int unsigned TAIL_CYCLES = 40;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       text_done;
	} decoded_t;

	// expected decoded bytes plus a private copy of the entity state
	class entity_scoreboard;
		decoded_t    expected_q[$];
		decoded_t    item_bytes[$];
		logic [7:0]  body[BODY_MAX];
		int unsigned body_len = 0;
		bit          holding = 0;
		int unsigned errors = 0;

		function int unsigned outstanding();
			return expected_q.size();
		endfunction

		function void emit(logic [7:0] b);
			decoded_t d;
			d.out_byte  = b;
			d.run_last  = 1'b0;
			d.text_done = 1'b0;
			if (item_bytes.size() < MAX_BYTES_PER_ITEM)
				item_bytes = {item_bytes, d};
		endfunction

		function bit body_equals(string name);
			int k;
			if (body_len != name.len())
				return 1'b0;
			for (k = 0; k < name.len(); k++)
				if (body[k] != name[k])
					return 1'b0;
			return 1'b1;
		endfunction

		function int hex_digit(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
			if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
			if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
			return -1;
		endfunction

		// -1 when the entity stays literal
		function int decode_entity();
			int unsigned code;
			int unsigned base;
			int          k;
			int          d;
			code = 0;
			if (body_equals("amp"))  return int'(CH_AMP);
			if (body_equals("lt"))   return int'(CH_LT);
			if (body_equals("gt"))   return int'(CH_GT);
			if (body_equals("quot")) return int'(CH_QUOT);
			if (body_equals("apos")) return int'(CH_APOS);
			if (body_equals("nbsp")) return int'(CH_SPACE);
			if (body_len == 0 || body[0] != CH_HASH)
				return -1;
			// "#x" alone falls to decimal and fails there
			if (body_len > 2 && (body[1] == CH_LX || body[1] == CH_UX)) begin
				base = 16;
				k = 2;
			end else begin
				base = 10;
				k = 1;
			end
			while (k < body_len) begin
				d = hex_digit(body[k]);
				if (d < 0 || (base == 10 && d > 9))
					return -1;
				code = code * base + d;
				if (code > CODE_CAP)
					code = CODE_CAP;
				k++;
			end
			if (code > 0 && code < CODE_CAP)
				return code;
			return -1;
		endfunction

		function void flush_literal();
			int k;
			emit(CH_AMP);
			for (k = 0; k < body_len; k++)
				emit(body[k]);
		endfunction

		function void scan_byte(logic [7:0] b);
			if (!holding) begin
				if (b == CH_AMP) begin
					holding = 1'b1;
					body_len = 0;
				end else begin
					emit(b);
				end
			end else if (body_len < BODY_MAX) begin
				body[body_len] = b;
				body_len++;
			end else begin
				emit(b);
			end
		endfunction

		// accepted input transfer: work out the bytes it releases
		function void note_byte(logic [7:0] b, logic last);
			logic [7:0] replay[$];
			int         k;
			int         d;
			item_bytes.delete();
			if (!holding) begin
				scan_byte(b);
			end else if (b == CH_SEMI) begin
				d = decode_entity();
				if (d >= 0) begin
					emit(d[7:0]);
				end else begin
					flush_literal();
					emit(CH_SEMI);
				end
				holding = 1'b0;
				body_len = 0;
			end else if (body_len < BODY_MAX) begin
				body[body_len] = b;
				body_len++;
			end else begin
				// no semicolon in reach: ampersand goes out, the rest is text again
				for (k = 0; k < body_len; k++)
					replay = {replay, body[k]};
				replay = {replay, b};
				holding = 1'b0;
				body_len = 0;
				emit(CH_AMP);
				foreach (replay[i])
					scan_byte(replay[i]);
			end
			if (last) begin
				if (holding)
					flush_literal();
				holding = 1'b0;
				body_len = 0;
			end
			if (item_bytes.size() > 0) begin
				item_bytes[item_bytes.size() - 1].run_last  = 1'b1;
				item_bytes[item_bytes.size() - 1].text_done = last;
			end
			foreach (item_bytes[i])
				expected_q = {expected_q, item_bytes[i]};
		endfunction

		// accepted output transfer against the oldest expectation
		function void check_byte(decoded_t got);
			decoded_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected output byte %h", got.out_byte);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte expected %h actual %h", want.out_byte, got.out_byte);
				errors++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last expected %b actual %b", want.run_last, got.run_last);
				errors++;
			end
			if (got.text_done !== want.text_done) begin
				$error("text_done expected %b actual %b", want.text_done, got.text_done);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	hed_in_if  raw_if();
	hed_out_if dec_if();

	html_entity_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.raw     (raw_if),
		.decoded (dec_if)
	);

	entity_scoreboard sb;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned bytes_sent = 0;
	int unsigned cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk)
		dec_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// output transfers are taken at the rising edge, before flops update
	always @(posedge clk) begin
		if (arst_n && dec_if.valid && dec_if.ready)
			sb.check_byte('{dec_if.out_byte, dec_if.run_last, dec_if.text_done});
	end

	// one input transfer, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			raw_if.valid <= 1'b0;
			@(negedge clk);
		end
		raw_if.valid     <= 1'b1;
		raw_if.in_byte   <= b;
		raw_if.text_last <= last;
		do
			@(posedge clk);
		while (!raw_if.ready);
		sb.note_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_text(input string s, input logic last_at_end);
		int k;
		for (k = 0; k < s.len(); k++)
			send_byte(s[k], last_at_end && (k == s.len() - 1));
	endtask

	// random text byte; now and then it closes the text
	task automatic put_byte(input logic [7:0] b);
		send_byte(b, $urandom_range(0, 24) == 0);
	endtask

	function automatic logic [7:0] hex_char(input bit upper);
		int unsigned v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return 8'(CH_0 + v);
		return 8'((upper ? CH_UA : CH_LA) + v - 10);
	endfunction

	// one random word: plain text and well-formed entities, with damaged
	// entities and over-long spans mixed in
	task automatic send_random_word();
		int unsigned kind;
		int unsigned n;
		int          k;
		logic [7:0]  c;
		string       name;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1: begin
				n = $urandom_range(1, 4);
				repeat (n) put_byte(8'($urandom_range(0, 255)));
			end
			2: begin
				case ($urandom_range(0, 5))
					0: name = "amp";
					1: name = "lt";
					2: name = "gt";
					3: name = "quot";
					4: name = "apos";
					default: name = "nbsp";
				endcase
				put_byte(CH_AMP);
				for (k = 0; k < name.len(); k++) begin
					c = name[k];
					// occasionally spoil a letter
					if ($urandom_range(0, 5) == 0)
						c = 8'(CH_LA + $urandom_range(0, 25));
					put_byte(c);
				end
				put_byte(CH_SEMI);
			end
			3: begin
				put_byte(CH_AMP);
				put_byte(CH_HASH);
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
				repeat (n) begin
					if ($urandom_range(0, 11) == 0)
						put_byte(8'(CH_LA + $urandom_range(0, 25)));
					else
						put_byte(8'(CH_0 + $urandom_range(0, 9)));
				end
				put_byte(CH_SEMI);
			end
			4: begin
				put_byte(CH_AMP);
				put_byte(CH_HASH);
				put_byte($urandom_range(0, 1) ? CH_UX : CH_LX);
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 7) : $urandom_range(1, 2);
				repeat (n) put_byte(hex_char(1'($urandom_range(0, 1))));
				put_byte(CH_SEMI);
			end
			5: begin
				// no semicolon within reach, so the span is rescanned
				put_byte(CH_AMP);
				n = $urandom_range(9, 12);
				repeat (n) begin
					c = 8'($urandom_range(0, 255));
					if (c == CH_SEMI || $urandom_range(0, 9) == 0)
						c = CH_AMP;
					put_byte(c);
				end
			end
			6: begin
				put_byte(CH_AMP);
				n = $urandom_range(0, 9);
				repeat (n) begin
					c = 8'($urandom_range(0, 255));
					if (c == CH_SEMI)
						c = CH_HASH;
					put_byte(c);
				end
				put_byte(CH_SEMI);
			end
			7: begin
				case ($urandom_range(0, 4))
					0: name = "&;";
					1: name = "&#;";
					2: name = "&#x;";
					3: name = "&#0;";
					default: name = "&#128;";
				endcase
				for (k = 0; k < name.len(); k++)
					put_byte(name[k]);
			end
			default: begin
				n = $urandom_range(1, 6);
				repeat (n) put_byte(($urandom_range(0, 4) == 0) ? CH_SPACE
					: 8'(CH_LA + $urandom_range(0, 25)));
			end
		endcase
	endtask

	// sender holds off until every expected byte has come out
	task automatic wait_drained();
		@(negedge clk);
		raw_if.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic run_random_phase(input int unsigned count);
		int unsigned phase_start;
		phase_start = bytes_sent;
		while (bytes_sent - phase_start < count)
			send_random_word();
		// close the text so nothing stays held across the pause
		send_byte(8'($urandom_range(0, 255)), 1'b1);
		wait_drained();
	endtask

	initial begin
		sb = new();
		arst_n           = 1'b0;
		raw_if.valid     = 1'b0;
		raw_if.in_byte   = 8'h00;
		raw_if.text_last = 1'b0;
		dec_if.ready     = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// phase one: sender mostly busy, receiver mostly stalled
		send_idle_pct = 27;
		recv_idle_pct = 69;

		// directed: x with no digits, code zero, lone hash, empty body
		send_text("&#x;", 1'b0);
		send_text("&#0;", 1'b0);
		send_text("&#;", 1'b0);
		send_text("&;", 1'b0);
		// over-long span with a second ampersand inside, flushed by end of
		// text: the item on the last byte gives the most output bytes
		send_text("&1234567&9x", 1'b1);
		// byte extremes, the last one ending the text
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);

		run_random_phase(125);

		// phase two: roles swapped
		send_idle_pct = 69;
		recv_idle_pct = 27;
		run_random_phase(125);

		// phase three: full rate both ways
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_phase(124);

		// watch for stray bytes after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.outstanding() != 0) begin
			$error("%0d expected output bytes never arrived", sb.outstanding());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
